>>> hdl/sit_pkg.sv
// Package for the sorted insertion table.
// Holds request/response types, cell record and control types, and codes.
// No dependencies.
package sit_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned KeyW         = 10;
  localparam int unsigned SemW         = 4;
  localparam int unsigned TagW         = 8;
  localparam int unsigned CountW       = 5;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_LIST   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_LISTED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    FSM_IDLE = 1'b0,
    FSM_LIST = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [KeyW-1:0]   key;
    logic [SemW-1:0]   semester;
    logic [TagW-1:0]   record_tag;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [KeyW-1:0]   out_key;
    logic [SemW-1:0]   out_semester;
    logic [TagW-1:0]   out_tag;
    logic [CountW-1:0] entry_count;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [SemW-1:0] semester;
    logic [TagW-1:0] tag;
  } rec_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic ins;  // insert new record, shift lower entries down
    logic rot;  // rotate table up by one, head wraps to tail
  } cell_ctl_t;

endpackage

>>> hdl/sorted_insertion_table_top.sv
// Sorted insertion table, top level: a chain of DEPTH record cells kept in
// descending key order, plus sit_ctrl for sequencing. Uses sit_pkg.
//
// Usage: on an insert request every cell compares the new key with its own in
// parallel and the cells at or below the insert point shift down by one, so
// equal keys go newest first. An insert into a full table leaves it unchanged
// and returns a full status. A list request streams the entries from cell 0,
// one per cycle while the output is not stalled, as the chain rotates up by
// one with each entry sent; the input is stalled while the list runs, the
// table is left as it was and the last entry carries last. Listing an empty
// table returns one empty status. The next request is taken in the cycle
// after the final response of the previous one is loaded, provided the
// response register is free or being drained; a stalled output holds the
// block.
module sorted_insertion_table_top #(
  parameter int unsigned DEPTH = sit_pkg::DepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sit_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sit_pkg::rsp_t out_rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  sit_pkg::cell_ctl_t ctl;
  logic [CW-1:0]      count;
  sit_pkg::rec_t      recs [DEPTH];
  logic [DEPTH-1:0]   ge;
  sit_pkg::rec_t      new_rec;

  assign new_rec.key      = in_req_i.key;
  assign new_rec.semester = in_req_i.semester;
  assign new_rec.tag      = in_req_i.record_tag;

  sit_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .head_rec_i  (recs[0]),
    .count_o     (count),
    .ctl_o       (ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          valid;
    logic          tail;
    logic          prev_ge;
    sit_pkg::rec_t prev_rec;
    sit_pkg::rec_t next_rec;

    assign valid = (CW'(i) < count);
    assign tail  = ((CW+1)'(i + 1) == (CW+1)'(count));

    if (i == 0) begin : g_first
      assign prev_ge  = 1'b0;
      assign prev_rec = new_rec;
    end else begin : g_mid
      assign prev_ge  = ge[i-1];
      assign prev_rec = recs[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_rec = recs[0];
    end else begin : g_inner
      assign next_rec = recs[i+1];
    end

    sit_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .valid_i    (valid),
      .tail_i     (tail),
      .prev_ge_i  (prev_ge),
      .prev_rec_i (prev_rec),
      .next_rec_i (next_rec),
      .head_rec_i (recs[0]),
      .new_rec_i  (new_rec),
      .ge_o       (ge[i]),
      .rec_o      (recs[i])
    );
  end

endmodule

>>> hdl/sit_cell.sv
// One table cell: holds a record, compares against the incoming key and
// takes data from a neighbor, the new record or the head. Uses sit_pkg.
module sit_cell (
  input  logic              clk_i,
  input  sit_pkg::cell_ctl_t ctl_i,
  input  logic              valid_i,
  input  logic              tail_i,
  input  logic              prev_ge_i,
  input  sit_pkg::rec_t     prev_rec_i,
  input  sit_pkg::rec_t     next_rec_i,
  input  sit_pkg::rec_t     head_rec_i,
  input  sit_pkg::rec_t     new_rec_i,
  output logic              ge_o,
  output sit_pkg::rec_t     rec_o
);

  sit_pkg::rec_t rec_q, rec_d;

  assign ge_o  = !valid_i || (new_rec_i.key >= rec_q.key);
  assign rec_o = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.ins && ge_o) begin
      rec_d = prev_ge_i ? prev_rec_i : new_rec_i;
    end else if (ctl_i.rot && valid_i) begin
      rec_d = tail_i ? head_rec_i : next_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

>>> hdl/sit_ctrl.sv
// Control for the sorted insertion table: fill count, list sequencer,
// request handshake and response register. Uses sit_pkg.
module sit_ctrl #(
  parameter int unsigned DEPTH = sit_pkg::DepthDefault,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sit_pkg::req_t      in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sit_pkg::rsp_t      out_rsp_o,
  input  sit_pkg::rec_t      head_rec_i,
  output logic [CW-1:0]      count_o,
  output sit_pkg::cell_ctl_t ctl_o
);

  sit_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  sit_pkg::rsp_t   rsp_q, rsp_d;
  logic            load_ok;
  logic            acc;
  logic            full;
  logic [CW+4:0]   cnt_ext;
  logic [CW+4:0]   cnt_inc_ext;
  logic            is_last;

  assign load_ok     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != sit_pkg::FSM_IDLE) || !load_ok;
  assign acc         = in_valid_i && !in_stall_o;
  assign full        = (count_q == CW'(DEPTH));
  assign cnt_ext     = (CW+5)'(count_q);
  assign cnt_inc_ext = (CW+5)'(count_q) + (CW+5)'(1);
  assign is_last     = ((idx_q + CW'(1)) == count_q);

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign count_o     = count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl_o       = '0;
    unique case (state_q)
      sit_pkg::FSM_IDLE: begin
        if (acc) begin
          rsp_d      = '0;
          rsp_d.last = 1'b1;
          if (in_req_i.command == sit_pkg::CMD_INSERT) begin
            out_valid_d = 1'b1;
            if (full) begin
              rsp_d.status      = sit_pkg::ST_FULL;
              rsp_d.entry_count = cnt_ext[4:0];
            end else begin
              ctl_o.ins         = 1'b1;
              count_d           = count_q + CW'(1);
              rsp_d.status      = sit_pkg::ST_INSERTED;
              rsp_d.entry_count = cnt_inc_ext[4:0];
            end
          end else if (count_q == '0) begin
            out_valid_d       = 1'b1;
            rsp_d.status      = sit_pkg::ST_EMPTY;
            rsp_d.entry_count = cnt_ext[4:0];
          end else begin
            state_d = sit_pkg::FSM_LIST;
            idx_d   = '0;
          end
        end
      end
      sit_pkg::FSM_LIST: begin
        if (load_ok) begin
          out_valid_d        = 1'b1;
          ctl_o.rot          = 1'b1;
          rsp_d.status       = sit_pkg::ST_LISTED;
          rsp_d.out_key      = head_rec_i.key;
          rsp_d.out_semester = head_rec_i.semester;
          rsp_d.out_tag      = head_rec_i.tag;
          rsp_d.entry_count  = cnt_ext[4:0];
          rsp_d.last         = is_last;
          idx_d              = idx_q + CW'(1);
          if (is_last) begin
            state_d = sit_pkg::FSM_IDLE;
          end
        end
      end
      default: state_d = sit_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sit_pkg::FSM_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_ctl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.ins && ctl_o.rot))
    else $error("insert and rotate together");

  a_list_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sit_pkg::FSM_LIST) |-> in_stall_o)
    else $error("request taken during list");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_req_i.command == sit_pkg::CMD_INSERT && !full)
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not bump count");

endmodule
